>>> hdl/cbh_pkg.sv
package cbh_pkg;

    localparam int ROWS = 128;
    localparam int COLS = 128;
    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CELLS = ROWS * COLS;
    localparam int BUMP_DEPTH = ROWS / 20;

    localparam int H_W = 24;
    localparam int PEAK_W = 23;
    localparam int CHG_W = 11;
    localparam int DSQ_IDX_W = 9;
    localparam int CHG_AW = 2 + DSQ_IDX_W;
    localparam int CHG_DEPTH = 1 << CHG_AW;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BUMP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

    localparam int RADIUS [4] = '{ROWS / 4, ROWS / 5, ROWS / 6, ROWS / 7};

    typedef logic [CHG_W-1:0] chg_tab_t [CHG_DEPTH];

    typedef struct packed {
        logic start;
        logic [31:0] num;
        logic [PEAK_W-1:0] den;
    } cbh_div_req_t;

    typedef struct packed {
        logic done;
        logic [7:0] quot;
    } cbh_div_rsp_t;

    function automatic logic [10:0] radius_sq(input logic [1:0] idx);
        logic [10:0] r2;
        case (idx)
            2'd0: r2 = 11'(RADIUS[0] * RADIUS[0]);
            2'd1: r2 = 11'(RADIUS[1] * RADIUS[1]);
            2'd2: r2 = 11'(RADIUS[2] * RADIUS[2]);
            default: r2 = 11'(RADIUS[3] * RADIUS[3]);
        endcase
        return r2;
    endfunction

    // raised cosine weight in q0.16, then depth-scaled change in q3.8
    function automatic chg_tab_t build_chg_tab();
        chg_tab_t tab;
        longint unsigned w [257];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned u;
        longint unsigned lim;
        longint unsigned c;
        longint unsigned p;
        longint unsigned qv;
        longint sum;
        longint s;
        int q;
        int k;
        int dv;
        int d;
        int b;
        for (q = 0; q <= 256; q++)
        begin
            x = (64'(q) * 64'd329252864) / 64'd100;
            x2 = (x * x) >> 28;
            term = 64'd268435456;
            sum = 64'sd268435456;
            for (k = 0; k < 15; k++)
            begin
                term = ((term * x2) >> 28) / 64'((2 * k + 1) * (2 * k + 2));
                if ((k % 2) == 0)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            s = 64'sd268435456 + sum;
            if (s < 0)
                s = 0;
            u = (64'(s) + 64'd4096) >> 13;
            if (u > 64'd65536)
                u = 64'd65536;
            w[q] = u;
        end
        for (dv = 0; dv < 4; dv++)
        begin
            for (d = 0; d < (1 << DSQ_IDX_W); d++)
            begin
                lim = 64'd262144 * 64'(d);
                qv = 0;
                for (b = 8; b >= 0; b--)
                begin
                    c = qv | (64'd1 << b);
                    p = c * 64'(RADIUS[dv]);
                    if (c <= 64'd256 && p * p <= lim)
                        qv = c;
                end
                tab[dv * (1 << DSQ_IDX_W) + d] =
                    CHG_W'((64'(BUMP_DEPTH) * w[int'(qv)] + 64'd128) >> 8);
            end
        end
        return tab;
    endfunction

endpackage

>>> hdl/cbh_if.sv
interface cbh_in_if;
    logic valid;
    logic ready;
    logic [1:0] op;
    logic [6:0] center_row;
    logic [6:0] center_col;
    logic [2:0] radius_divisor;
    logic [6:0] cell_row;
    logic [6:0] cell_col;

    modport source (output valid, op, center_row, center_col, radius_divisor, cell_row,
                    cell_col, input ready);
    modport sink (input valid, op, center_row, center_col, radius_divisor, cell_row,
                  cell_col, output ready);
endinterface

interface cbh_out_if;
    logic valid;
    logic ready;
    logic signed [23:0] cell_height;
    logic [22:0] peak_depth;
    logic [7:0] shade;

    modport source (output valid, cell_height, peak_depth, shade, input ready);
    modport sink (input valid, cell_height, peak_depth, shade, output ready);
endinterface

>>> hdl/cbh_ram.sv
module cbh_ram #(
    parameter int DATA_W = 24,
    parameter int ADDR_W = 14
) (
    input  logic clk,
    input  logic wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/cbh_rom.sv
module cbh_rom import cbh_pkg::*; (
    input  logic clk,
    input  logic [CHG_AW-1:0] addr,
    output logic [CHG_W-1:0] data
);

    localparam chg_tab_t CHG_TAB = build_chg_tab();

    always_ff @(posedge clk)
    begin
        data <= CHG_TAB[addr];
    end

endmodule

>>> hdl/cbh_shade_div.sv
module cbh_shade_div import cbh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  cbh_div_req_t req,
    output cbh_div_rsp_t rsp
);

    logic busy_reg;
    logic done_reg;
    logic [3:0] step_reg;
    logic [31:0] rem_reg;
    logic [PEAK_W-1:0] den_reg;
    logic [8:0] q_reg;
    logic [31:0] trial;

    assign trial = 32'(den_reg) << step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.start ? (req.den == '0) : (busy_reg && step_reg == 4'd0);
            if (req.start)
                busy_reg <= (req.den != '0);
            else if (busy_reg && step_reg == 4'd0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num;
            den_reg <= req.den;
            q_reg <= '0;
            step_reg <= 4'd8;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                q_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - 4'd1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg[8] ? 8'd255 : q_reg[7:0];

endmodule

>>> hdl/circle_bump_heightmap.sv
// Heightmap of 128 x 128 signed q15.8 cells in one single-port-read, single-port-write
// memory, walked by a sequencer one cell per cycle. After reset the block runs a clearing
// pass over every cell and accepts no beat until it ends. A clear sweeps every cell; a bump
// runs the read-modify-write pipe over every cell (the change coming from a registered table
// indexed by squared distance) and then a tail step; a read does the memory read, then a
// 9-step shade divider that finishes without stepping while the peak is zero, then the result
// load. One command is in work at a time; a new command is taken while the previous result
// still waits in the output register.
module circle_bump_heightmap import cbh_pkg::*; (
    input logic clk,
    input logic rst_n,
    cbh_in_if.sink cmd,
    cbh_out_if.source res
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_BUMP = 3'd2;
    localparam logic [2:0] ST_TAIL = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_DIV = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    logic [2:0] state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic init_reg, init_next;
    logic [6:0] crow_reg, crow_next;
    logic [6:0] ccol_reg, ccol_next;
    logic [1:0] div_reg, div_next;
    logic [PEAK_W-1:0] peak_reg, peak_next;
    logic [H_W-1:0] res_h_reg, res_h_next;
    logic [7:0] res_shade_reg, res_shade_next;
    logic out_valid_reg, out_valid_next;
    logic [H_W-1:0] out_h_reg;
    logic [PEAK_W-1:0] out_peak_reg;
    logic [7:0] out_shade_reg;
    logic v1_reg;
    logic [ADDR_W-1:0] a1_reg;

    logic accept;
    logic load_out;
    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [H_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [H_W-1:0] rd_data;
    logic [CHG_W-1:0] chg;

    logic signed [7:0] dr, dc;
    logic signed [15:0] drr, dcc;
    logic [15:0] dsq;
    logic in_circle;

    logic signed [H_W:0] nh_wide;
    logic [H_W-1:0] nh;
    logic [H_W-1:0] nh_mag;
    logic [PEAK_W-1:0] nh_mag_sat;
    logic [H_W-1:0] rd_mag;

    cbh_div_req_t div_req;
    cbh_div_rsp_t div_rsp;

    cbh_ram #(.DATA_W(H_W), .ADDR_W(ADDR_W)) u_ram (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    cbh_rom u_rom (
        .clk(clk),
        .addr({div_reg, dsq[DSQ_IDX_W-1:0]}),
        .data(chg)
    );

    cbh_shade_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .req(div_req),
        .rsp(div_rsp)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept = cmd.valid && cmd.ready;

    // distance of the current cell from the bump center
    assign dr = signed'({1'b0, cnt_reg[ADDR_W-1:COL_W]}) - signed'({1'b0, crow_reg});
    assign dc = signed'({1'b0, cnt_reg[COL_W-1:0]}) - signed'({1'b0, ccol_reg});
    assign drr = dr * dr;
    assign dcc = dc * dc;
    assign dsq = 16'(drr) + 16'(dcc);
    assign in_circle = ({dsq, 2'b00} <= 18'(radius_sq(div_reg)));

    // second pipe step: subtract and saturate
    assign nh_wide = signed'({rd_data[H_W-1], rd_data}) - signed'({{(H_W+1-CHG_W){1'b0}}, chg});
    assign nh = (nh_wide[H_W] && !nh_wide[H_W-1]) ? {1'b1, {(H_W-1){1'b0}}} : nh_wide[H_W-1:0];
    assign nh_mag = nh[H_W-1] ? (~nh + H_W'(1)) : nh;
    assign nh_mag_sat = nh_mag[H_W-1] ? PEAK_MAX : nh_mag[PEAK_W-1:0];
    assign rd_mag = rd_data[H_W-1] ? (~rd_data + H_W'(1)) : rd_data;

    assign rd_addr = (state_reg == ST_IDLE) ? ADDR_W'({cmd.cell_row, cmd.cell_col}) : cnt_reg;

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = cnt_reg;
        wr_data = '0;
        if (v1_reg)
        begin
            wr_en = 1'b1;
            wr_addr = a1_reg;
            wr_data = nh;
        end
        else if (state_reg == ST_CLEAR)
        begin
            wr_en = 1'b1;
        end
    end

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        init_next = init_reg;
        crow_next = crow_reg;
        ccol_next = ccol_reg;
        div_next = div_reg;
        peak_next = peak_reg;
        res_h_next = res_h_reg;
        res_shade_next = res_shade_reg;
        div_req.start = 1'b0;
        div_req.num = 32'(rd_mag) * 32'd255;
        div_req.den = peak_reg;

        if (v1_reg && nh_mag_sat > peak_reg)
            peak_next = nh_mag_sat;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_h_next = '0;
                    res_shade_next = '0;
                    cnt_next = '0;
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            peak_next = '0;
                            state_next = ST_CLEAR;
                        end
                        OP_BUMP:
                        begin
                            crow_next = cmd.center_row;
                            ccol_next = cmd.center_col;
                            div_next = cmd.radius_divisor[2] ? cmd.radius_divisor[1:0] : 2'd0;
                            state_next = ST_BUMP;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    init_next = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_BUMP:
            begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_CELL)
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                res_h_next = rd_data;
                div_req.start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_shade_next = div_rsp.quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !res.ready) || load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            init_reg <= 1'b1;
            peak_reg <= '0;
            out_valid_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            init_reg <= init_next;
            peak_reg <= peak_next;
            out_valid_reg <= out_valid_next;
            v1_reg <= (state_reg == ST_BUMP) && in_circle;
        end
    end

    always_ff @(posedge clk)
    begin
        crow_reg <= crow_next;
        ccol_reg <= ccol_next;
        div_reg <= div_next;
        res_h_reg <= res_h_next;
        res_shade_reg <= res_shade_next;
        a1_reg <= cnt_reg;
        if (load_out)
        begin
            out_h_reg <= res_h_reg;
            out_peak_reg <= peak_reg;
            out_shade_reg <= res_shade_reg;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.cell_height = signed'(out_h_reg);
    assign res.peak_depth = out_peak_reg;
    assign res.shade = out_shade_reg;

    a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !v1_reg) |-> !wr_en)
        else $error("memory written while idle");

    a_clear_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (peak_reg == '0))
        else $error("peak not cleared during clear pass");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside shade step");

    a_pipe_only_in_bump: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> ($past(state_reg) == ST_BUMP))
        else $error("bump write without bump sweep");

endmodule
